/* rtl/dpw_pkg.sv */
// dpw_pkg: shared types, register indexes and constants for the depth pixel
// to world point pipeline. No dependencies; used by every file under rtl.
package dpw_pkg;

  // Parameter defaults
  localparam int SAMPLE_STRIDE_DEF = 3;
  localparam int COORD_BITS_DEF    = 12;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] REG_DEPTH_LIMITS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INTRINSICS   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_X        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_Y        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_Z        = 3'd4;

  // Register reset values: limits 41..40960, cx 320, cy 240, 1/f 125/65536,
  // identity transform
  localparam logic [31:0] LIMITS_RESET = 32'hA000_0029;
  localparam logic [63:0] INTR_RESET   = 64'h007D_007D_0F00_1400;
  localparam logic [63:0] ROWX_RESET   = 64'h0000_0000_0000_4000;
  localparam logic [63:0] ROWY_RESET   = 64'h0000_0000_4000_0000;
  localparam logic [63:0] ROWZ_RESET   = 64'h0000_4000_0000_0000;

  // Output point range
  localparam int PT_MAX = 524287;
  localparam int PT_MIN = -524288;

  typedef struct packed {
    logic [15:0] depth_value;
    logic [11:0] pixel_row;
    logic [11:0] pixel_col;
    logic [7:0]  blue_in;
    logic [7:0]  green_in;
    logic [7:0]  red_in;
    logic        frame_end_in;
  } in_item_t;

  typedef struct packed {
    logic signed [19:0] point_x;
    logic signed [19:0] point_y;
    logic signed [19:0] point_z;
    logic [7:0]         blue_out;
    logic [7:0]         green_out;
    logic [7:0]         red_out;
    logic               kept;
    logic               frame_end_out;
  } out_item_t;

  // Control and pass-through data that rides along each pipeline stage
  typedef struct packed {
    logic       valid;
    logic       keep;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic       frame_end;
  } dpw_side_t;

endpackage

/* rtl/dpw_front.sv */
// dpw_front: stages A and B. Depth and stride tests, principal point offset,
// and the offset times depth products. Depends on dpw_pkg.
module dpw_front #(
  parameter int SAMPLE_STRIDE = dpw_pkg::SAMPLE_STRIDE_DEF,
  parameter int COORD_BITS    = dpw_pkg::COORD_BITS_DEF,
  parameter int UDW           = 34
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_take,
  input  dpw_pkg::in_item_t     in_item,
  input  logic [31:0]           depth_limits,
  input  logic [31:0]           cxcy,
  output dpw_pkg::dpw_side_t    side_o,
  output logic signed [UDW-1:0] ud_o,
  output logic signed [UDW-1:0] vd_o,
  output logic [15:0]           d_o
);

  localparam int UW   = ((COORD_BITS + 4) > 16 ? (COORD_BITS + 4) : 16) + 1;
  // Reciprocal for the stride remainder: exact for all COORD_BITS-bit values
  localparam int SH   = COORD_BITS + 3;
  localparam int MW   = SH + 1;
  localparam int QPW  = COORD_BITS + MW;
  localparam logic [MW-1:0] RECIP = MW'((2**SH + SAMPLE_STRIDE - 1) / SAMPLE_STRIDE);

  // Stage A registers
  dpw_pkg::dpw_side_t    a_side_r, a_side_nxt;
  logic [15:0]           a_d_r;
  logic signed [UW-1:0]  a_u_r, a_u_nxt;
  logic signed [UW-1:0]  a_v_r, a_v_nxt;
  logic [COORD_BITS-1:0] a_row_r, a_col_r;
  logic [COORD_BITS-1:0] a_qrow_r, a_qcol_r;

  // Stage B registers
  dpw_pkg::dpw_side_t    b_side_r, b_side_nxt;
  logic signed [UDW-1:0] b_ud_r, b_ud_nxt;
  logic signed [UDW-1:0] b_vd_r, b_vd_nxt;
  logic [15:0]           b_d_r;

  logic [COORD_BITS-1:0] row_m, col_m;
  logic [QPW-1:0]        row_prod, col_prod;
  logic                  depth_ok;
  logic                  stride_ok;

  // Stage A: coordinate wrap, depth window, offsets, stride quotients
  always_comb begin
    row_m    = COORD_BITS'(in_item.pixel_row);
    col_m    = COORD_BITS'(in_item.pixel_col);
    depth_ok = (in_item.depth_value >= depth_limits[15:0]) &&
               (in_item.depth_value <= depth_limits[31:16]);
    row_prod = QPW'(row_m) * QPW'(RECIP);
    col_prod = QPW'(col_m) * QPW'(RECIP);
    a_u_nxt  = $signed(UW'({col_m, 4'b0000})) - $signed(UW'(cxcy[15:0]));
    a_v_nxt  = $signed(UW'({row_m, 4'b0000})) - $signed(UW'(cxcy[31:16]));

    a_side_nxt.valid     = in_take;
    a_side_nxt.keep      = depth_ok;
    a_side_nxt.blue      = in_item.blue_in;
    a_side_nxt.green     = in_item.green_in;
    a_side_nxt.red       = in_item.red_in;
    a_side_nxt.frame_end = in_item.frame_end_in;
  end

  // Stage B: stride check and offset times depth
  always_comb begin
    stride_ok  = (QPW'(a_qrow_r) * QPW'(SAMPLE_STRIDE) == QPW'(a_row_r)) &&
                 (QPW'(a_qcol_r) * QPW'(SAMPLE_STRIDE) == QPW'(a_col_r));
    b_ud_nxt   = UDW'(a_u_r) * UDW'($signed({1'b0, a_d_r}));
    b_vd_nxt   = UDW'(a_v_r) * UDW'($signed({1'b0, a_d_r}));
    b_side_nxt      = a_side_r;
    b_side_nxt.keep = a_side_r.keep & stride_ok;
  end

  // Side registers with their valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_side_r <= '0;
      b_side_r <= '0;
    end else begin
      a_side_r <= a_side_nxt;
      b_side_r <= b_side_nxt;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    a_d_r    <= in_item.depth_value;
    a_u_r    <= a_u_nxt;
    a_v_r    <= a_v_nxt;
    a_row_r  <= row_m;
    a_col_r  <= col_m;
    a_qrow_r <= row_prod[SH +: COORD_BITS];
    a_qcol_r <= col_prod[SH +: COORD_BITS];
    b_ud_r   <= b_ud_nxt;
    b_vd_r   <= b_vd_nxt;
    b_d_r    <= a_d_r;
  end

  assign side_o = b_side_r;
  assign ud_o   = b_ud_r;
  assign vd_o   = b_vd_r;
  assign d_o    = b_d_r;

endmodule

/* rtl/dpw_scale.sv */
// dpw_scale: stages C and D. Scales by the inverse focal lengths and rounds
// to camera coordinates in 1/65536 m. Depends on dpw_pkg.
module dpw_scale #(
  parameter int UDW  = 34,
  parameter int CAMW = 36
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  dpw_pkg::dpw_side_t     side_i,
  input  logic signed [UDW-1:0]  ud_i,
  input  logic signed [UDW-1:0]  vd_i,
  input  logic [15:0]            d_i,
  input  logic [31:0]            inv_f,
  output dpw_pkg::dpw_side_t     side_o,
  output logic signed [CAMW-1:0] cam_x_o,
  output logic signed [CAMW-1:0] cam_y_o,
  output logic signed [CAMW-1:0] cam_z_o
);

  localparam int P = UDW + 17;
  localparam logic [P:0] RND16 = (P + 1)'(32768);

  // Stage C registers
  dpw_pkg::dpw_side_t    c_side_r;
  logic signed [P-1:0]   c_px_r, c_px_nxt;
  logic signed [P-1:0]   c_py_r, c_py_nxt;
  logic [15:0]           c_d_r;

  // Stage D registers
  dpw_pkg::dpw_side_t    d_side_r;
  logic signed [CAMW-1:0] d_cx_r, d_cx_nxt;
  logic signed [CAMW-1:0] d_cy_r, d_cy_nxt;
  logic signed [CAMW-1:0] d_cz_r, d_cz_nxt;

  logic [P:0] px_rnd, py_rnd;

  // Stage C: times 1/fx and 1/fy (Q0.16)
  always_comb begin
    c_px_nxt = P'(ud_i) * P'($signed({1'b0, inv_f[15:0]}));
    c_py_nxt = P'(vd_i) * P'($signed({1'b0, inv_f[31:16]}));
  end

  // Stage D: round half up by 2^16; z is depth in 1/65536 m
  always_comb begin
    px_rnd   = {c_px_r[P-1], c_px_r} + RND16;
    py_rnd   = {c_py_r[P-1], c_py_r} + RND16;
    d_cx_nxt = $signed(px_rnd[P:16]);
    d_cy_nxt = $signed(py_rnd[P:16]);
    d_cz_nxt = $signed(CAMW'({c_d_r, 4'b0000}));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_side_r <= '0;
      d_side_r <= '0;
    end else begin
      c_side_r <= side_i;
      d_side_r <= c_side_r;
    end
  end

  always_ff @(posedge clk) begin
    c_px_r <= c_px_nxt;
    c_py_r <= c_py_nxt;
    c_d_r  <= d_i;
    d_cx_r <= d_cx_nxt;
    d_cy_r <= d_cy_nxt;
    d_cz_r <= d_cz_nxt;
  end

  assign side_o  = d_side_r;
  assign cam_x_o = d_cx_r;
  assign cam_y_o = d_cy_r;
  assign cam_z_o = d_cz_r;

endmodule

/* rtl/dpw_xform.sv */
// dpw_xform: stages E, F and G. Rigid 3x4 transform, rounding to 1/4096 m,
// saturation and the output register. Depends on dpw_pkg.
module dpw_xform #(
  parameter int CAMW = 36
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  dpw_pkg::dpw_side_t     side_i,
  input  logic signed [CAMW-1:0] cam_x_i,
  input  logic signed [CAMW-1:0] cam_y_i,
  input  logic signed [CAMW-1:0] cam_z_i,
  input  logic [2:0][63:0]       rows,
  output logic                   out_valid,
  output dpw_pkg::out_item_t     out_item
);

  localparam int PW = CAMW + 16;
  localparam int SW = PW + 3;
  localparam int RW = SW - 18;
  localparam logic [SW-1:0]        RND18  = SW'(131072);
  localparam logic signed [RW-1:0] SAT_HI = RW'(dpw_pkg::PT_MAX);
  localparam logic signed [RW-1:0] SAT_LO = RW'(dpw_pkg::PT_MIN);

  // Stage E: the nine rotation products
  dpw_pkg::dpw_side_t  e_side_r;
  logic signed [PW-1:0] e_prod_r   [3][3];
  logic signed [PW-1:0] e_prod_nxt [3][3];

  // Stage F: summed and rounded coordinates
  dpw_pkg::dpw_side_t  f_side_r;
  logic signed [RW-1:0] f_pt_r   [3];
  logic signed [RW-1:0] f_pt_nxt [3];

  // Stage G: output register
  logic                 g_valid_r;
  dpw_pkg::out_item_t   g_item_r, g_item_nxt;

  logic signed [CAMW-1:0] cam [3];
  logic [SW-1:0]          acc [3];
  logic signed [19:0]     sat [3];

  always_comb begin
    cam[0] = cam_x_i;
    cam[1] = cam_y_i;
    cam[2] = cam_z_i;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        e_prod_nxt[i][j] = PW'($signed(rows[i][16*j +: 16])) * PW'(cam[j]);
      end
    end
  end

  // Sum plus translation scaled by 2^18, round half up by 2^18
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      acc[i] = SW'(e_prod_r[i][0]) + SW'(e_prod_r[i][1]) + SW'(e_prod_r[i][2]) +
               (SW'($signed(rows[i][63:48])) <<< 18) + RND18;
      f_pt_nxt[i] = $signed(acc[i][SW-1:18]);
    end
  end

  // Saturate, zero the point when the pixel is dropped
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (!f_side_r.keep) begin
        sat[i] = '0;
      end else if (f_pt_r[i] > SAT_HI) begin
        sat[i] = SAT_HI[19:0];
      end else if (f_pt_r[i] < SAT_LO) begin
        sat[i] = SAT_LO[19:0];
      end else begin
        sat[i] = f_pt_r[i][19:0];
      end
    end
    g_item_nxt.point_x       = sat[0];
    g_item_nxt.point_y       = sat[1];
    g_item_nxt.point_z       = sat[2];
    g_item_nxt.blue_out      = f_side_r.blue;
    g_item_nxt.green_out     = f_side_r.green;
    g_item_nxt.red_out       = f_side_r.red;
    g_item_nxt.kept          = f_side_r.keep;
    g_item_nxt.frame_end_out = f_side_r.frame_end;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_side_r  <= '0;
      f_side_r  <= '0;
      g_valid_r <= 1'b0;
    end else begin
      e_side_r  <= side_i;
      f_side_r  <= e_side_r;
      g_valid_r <= f_side_r.valid;
    end
  end

  always_ff @(posedge clk) begin
    e_prod_r <= e_prod_nxt;
    f_pt_r   <= f_pt_nxt;
    g_item_r <= g_item_nxt;
  end

  assign out_valid = g_valid_r;
  assign out_item  = g_item_r;

endmodule

/* rtl/depth_pixel_to_world_point.sv */
// depth_pixel_to_world_point: top level with configuration registers and the
// seven-stage pipeline. Depends on dpw_pkg, dpw_front, dpw_scale, dpw_xform.
//
//   channel   ports                            handshake
//   input     start, busy, in_item             transfer when start && !busy
//   result    out_valid, out_item              one cycle strobe, no back-pressure
//   config    cfg_we, cfg_index, cfg_wdata     transfer when cfg_we
//
// One pixel per clock through seven register stages; the result strobe is high
// once its input transfer has passed through stages A to F into the G register.
// Latency is set by the multiplier chain: offset x depth, x 1/f, x rotation.
// busy is never raised, since the pipeline has no stall path.
// Synchronous active-low reset clears the valid bits and loads the default
// limits, intrinsics and identity transform.
module depth_pixel_to_world_point #(
  parameter int SAMPLE_STRIDE = dpw_pkg::SAMPLE_STRIDE_DEF,
  parameter int COORD_BITS    = dpw_pkg::COORD_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  dpw_pkg::in_item_t                in_item,
  output logic                             out_valid,
  output dpw_pkg::out_item_t               out_item,
  input  logic                             cfg_we,
  input  logic [dpw_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [dpw_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  localparam int UW   = ((COORD_BITS + 4) > 16 ? (COORD_BITS + 4) : 16) + 1;
  localparam int UDW  = UW + 17;
  localparam int CAMW = UDW + 2;

  logic [31:0]      limits_r;
  logic [63:0]      intr_r;
  logic [2:0][63:0] rows_r;

  dpw_pkg::dpw_side_t    fs_side, sc_side;
  logic signed [UDW-1:0] fs_ud, fs_vd;
  logic [15:0]           fs_d;
  logic signed [CAMW-1:0] cam_x, cam_y, cam_z;

  assign busy = 1'b0;

  // Configuration registers; unknown indexes are ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limits_r  <= dpw_pkg::LIMITS_RESET;
      intr_r    <= dpw_pkg::INTR_RESET;
      rows_r[0] <= dpw_pkg::ROWX_RESET;
      rows_r[1] <= dpw_pkg::ROWY_RESET;
      rows_r[2] <= dpw_pkg::ROWZ_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        dpw_pkg::REG_DEPTH_LIMITS: limits_r  <= cfg_wdata[31:0];
        dpw_pkg::REG_INTRINSICS:   intr_r    <= cfg_wdata;
        dpw_pkg::REG_ROW_X:        rows_r[0] <= cfg_wdata;
        dpw_pkg::REG_ROW_Y:        rows_r[1] <= cfg_wdata;
        dpw_pkg::REG_ROW_Z:        rows_r[2] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  dpw_front #(
    .SAMPLE_STRIDE (SAMPLE_STRIDE),
    .COORD_BITS    (COORD_BITS),
    .UDW           (UDW)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_take      (start && !busy),
    .in_item      (in_item),
    .depth_limits (limits_r),
    .cxcy         (intr_r[31:0]),
    .side_o       (fs_side),
    .ud_o         (fs_ud),
    .vd_o         (fs_vd),
    .d_o          (fs_d)
  );

  dpw_scale #(
    .UDW  (UDW),
    .CAMW (CAMW)
  ) u_scale (
    .clk     (clk),
    .rst_n   (rst_n),
    .side_i  (fs_side),
    .ud_i    (fs_ud),
    .vd_i    (fs_vd),
    .d_i     (fs_d),
    .inv_f   (intr_r[63:32]),
    .side_o  (sc_side),
    .cam_x_o (cam_x),
    .cam_y_o (cam_y),
    .cam_z_o (cam_z)
  );

  dpw_xform #(
    .CAMW (CAMW)
  ) u_xform (
    .clk       (clk),
    .rst_n     (rst_n),
    .side_i    (sc_side),
    .cam_x_i   (cam_x),
    .cam_y_i   (cam_y),
    .cam_z_i   (cam_z),
    .rows      (rows_r),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

/* verif/tb_top.sv */
// tb_top: self-checking bench for depth_pixel_to_world_point. It predicts each
// back-projected and transformed point in fixed point and compares every result.
// Depends on rtl/dpw_pkg.sv and rtl/depth_pixel_to_world_point.sv.
module tb_top;

  localparam int  STRIDE      = dpw_pkg::SAMPLE_STRIDE_DEF;
  localparam int  COORD_W     = dpw_pkg::COORD_BITS_DEF;
  localparam int  CIW         = dpw_pkg::CFG_IDX_W;
  localparam int  CDW         = dpw_pkg::CFG_DATA_W;
  localparam int  IN_W        = $bits(dpw_pkg::in_item_t);
  localparam int  CYCLE_LIMIT = 200000;
  localparam int  DRAIN_WAIT  = 12;
  localparam int  PRINT_CAP   = 40;

  logic                  clk;
  logic                  rst_n     = 1'b0;
  logic                  start     = 1'b0;
  logic                  busy;
  dpw_pkg::in_item_t     in_item   = '0;
  logic                  out_valid;
  dpw_pkg::out_item_t    out_item;
  logic                  cfg_we    = 1'b0;
  logic [CIW-1:0]        cfg_index = '0;
  logic [CDW-1:0]        cfg_wdata = '0;

  // Shadow copy of the block's registers
  logic [31:0] lim_reg  = dpw_pkg::LIMITS_RESET;
  logic [63:0] intr_reg = dpw_pkg::INTR_RESET;
  logic [63:0] xf_row [3] = '{dpw_pkg::ROWX_RESET, dpw_pkg::ROWY_RESET,
                              dpw_pkg::ROWZ_RESET};

  dpw_pkg::in_item_t  pixel_q [$];   // pixels waiting to be sent
  dpw_pkg::out_item_t point_q [$];   // predicted points, oldest first
  dpw_pkg::out_item_t want_item;
  int        send_idle_pct = 0;
  int        fault_count   = 0;
  int        result_idx    = 0;
  int        cycle_count   = 0;

  depth_pixel_to_world_point u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic report_fault(input string msg);
    fault_count++;
    if (fault_count <= PRINT_CAP) $display("ERROR result %0d: %s", result_idx, msg);
  endtask

  function automatic longint sx16(input logic [15:0] w);
    return longint'(signed'(w));
  endfunction

  // floor((a + 2^(k-1)) / 2^k): round half up
  function automatic longint round_q(input longint a, input int k);
    return (a + (longint'(1) <<< (k - 1))) >>> k;
  endfunction

  // Stride and depth gate, pinhole back-projection, rigid transform, clamp
  function automatic dpw_pkg::out_item_t project_pixel(input dpw_pkg::in_item_t px);
    dpw_pkg::out_item_t res;
    longint    d, u, v, acc, pt;
    longint    cam [3];
    logic [11:0] row, col;
    bit        keep;
    res  = '0;
    row  = px.pixel_row & 12'((1 << COORD_W) - 1);
    col  = px.pixel_col & 12'((1 << COORD_W) - 1);
    d    = longint'(px.depth_value);
    keep = (row % STRIDE == 0) && (col % STRIDE == 0) &&
           (px.depth_value >= lim_reg[15:0]) && (px.depth_value <= lim_reg[31:16]);
    if (keep) begin
      u = longint'(col) * 16 - longint'(intr_reg[15:0]);
      v = longint'(row) * 16 - longint'(intr_reg[31:16]);
      cam[0] = round_q(u * d * longint'(intr_reg[47:32]), 16);
      cam[1] = round_q(v * d * longint'(intr_reg[63:48]), 16);
      cam[2] = d * 16;
      for (int i = 0; i < 3; i++) begin
        acc = sx16(xf_row[i][63:48]) * (longint'(1) <<< 18);
        for (int k = 0; k < 3; k++) acc += sx16(xf_row[i][16*k +: 16]) * cam[k];
        pt = round_q(acc, 18);
        if (pt > dpw_pkg::PT_MAX) pt = dpw_pkg::PT_MAX;
        if (pt < dpw_pkg::PT_MIN) pt = dpw_pkg::PT_MIN;
        case (i)
          0: res.point_x = pt[19:0];
          1: res.point_y = pt[19:0];
          default: res.point_z = pt[19:0];
        endcase
      end
    end
    res.blue_out      = px.blue_in;
    res.green_out     = px.green_in;
    res.red_out       = px.red_in;
    res.kept          = keep;
    res.frame_end_out = px.frame_end_in;
    return res;
  endfunction

  function automatic dpw_pkg::in_item_t make_pixel(input logic [15:0] d,
                                                   input logic [11:0] row,
                                                   input logic [11:0] col,
                                                   input logic [7:0] b,
                                                   input logic [7:0] g,
                                                   input logic [7:0] r,
                                                   input logic fe);
    dpw_pkg::in_item_t px;
    px.depth_value  = d;
    px.pixel_row    = row;
    px.pixel_col    = col;
    px.blue_in      = b;
    px.green_in     = g;
    px.red_in       = r;
    px.frame_end_in = fe;
    return px;
  endfunction

  // Append one pixel to the send queue
  task automatic queue_pixel(input dpw_pkg::in_item_t px);
    pixel_q.insert(pixel_q.size(), px);
  endtask

  // Mostly pixels that pass the gate, with limit hits; the rest unconstrained
  task automatic add_random(input int n);
    dpw_pkg::in_item_t px;
    logic [95:0] raw;
    logic [15:0] dmin, dmax;
    repeat (n) begin
      raw  = {$urandom, $urandom, $urandom};
      px   = raw[IN_W-1:0];
      dmin = lim_reg[15:0];
      dmax = lim_reg[31:16];
      px.frame_end_in = ($urandom_range(0, 15) == 0);
      if ($urandom_range(0, 99) < 70) begin
        px.pixel_row = 12'(STRIDE * $urandom_range(0, 4095 / STRIDE));
        px.pixel_col = 12'(STRIDE * $urandom_range(0, 4095 / STRIDE));
        if (dmin <= dmax) begin
          case ($urandom_range(0, 7))
            0: px.depth_value = dmin;
            1: px.depth_value = dmax;
            default: px.depth_value = 16'($urandom_range(dmax, dmin));
          endcase
        end
      end
      queue_pixel(px);
    end
  endtask

  // One register write per clock; the shadow copy follows immediately
  task automatic write_reg(input logic [CIW-1:0] idx, input logic [63:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    case (idx)
      dpw_pkg::REG_DEPTH_LIMITS: lim_reg   = data[31:0];
      dpw_pkg::REG_INTRINSICS:   intr_reg  = data;
      dpw_pkg::REG_ROW_X:        xf_row[0] = data;
      dpw_pkg::REG_ROW_Y:        xf_row[1] = data;
      dpw_pkg::REG_ROW_Z:        xf_row[2] = data;
      default: ;
    endcase
  endtask

  task automatic write_setting(input logic [31:0] lim, input logic [63:0] intr,
                               input logic [63:0] rx, input logic [63:0] ry,
                               input logic [63:0] rz);
    write_reg(dpw_pkg::REG_DEPTH_LIMITS, {$urandom, lim});
    write_reg(dpw_pkg::REG_INTRINSICS, intr);
    write_reg(dpw_pkg::REG_ROW_X, rx);
    write_reg(dpw_pkg::REG_ROW_Y, ry);
    write_reg(dpw_pkg::REG_ROW_Z, rz);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Idle once nothing is queued, nothing is on the port and nothing is owed
  task automatic wait_idle();
    @(negedge clk);
    while (pixel_q.size() != 0 || start || point_q.size() != 0) @(negedge clk);
  endtask

  // Driver: record each transfer, then offer the next pixel or idle
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) point_q.insert(point_q.size(), project_pixel(in_item));
      if (start && busy) begin
        // hold the current pixel until it is taken
      end else if (pixel_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        start   <= 1'b1;
        in_item <= pixel_q.pop_front();
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: compare each result strobe against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (point_q.size() == 0) begin
        report_fault("result with no pixel outstanding");
      end else begin
        want_item = point_q.pop_front();
        if (out_item.point_x !== want_item.point_x)
          report_fault($sformatf("point_x got %h want %h",
                                 out_item.point_x, want_item.point_x));
        if (out_item.point_y !== want_item.point_y)
          report_fault($sformatf("point_y got %h want %h",
                                 out_item.point_y, want_item.point_y));
        if (out_item.point_z !== want_item.point_z)
          report_fault($sformatf("point_z got %h want %h",
                                 out_item.point_z, want_item.point_z));
        if (out_item.blue_out !== want_item.blue_out)
          report_fault($sformatf("blue got %h want %h",
                                 out_item.blue_out, want_item.blue_out));
        if (out_item.green_out !== want_item.green_out)
          report_fault($sformatf("green got %h want %h",
                                 out_item.green_out, want_item.green_out));
        if (out_item.red_out !== want_item.red_out)
          report_fault($sformatf("red got %h want %h",
                                 out_item.red_out, want_item.red_out));
        if (out_item.kept !== want_item.kept)
          report_fault($sformatf("kept got %b want %b", out_item.kept, want_item.kept));
        if (out_item.frame_end_out !== want_item.frame_end_out)
          report_fault($sformatf("frame_end got %b want %b",
                                 out_item.frame_end_out, want_item.frame_end_out));
      end
      result_idx++;
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed pixels under the reset registers: depth limits, stride, colors
    send_idle_pct = 28;
    queue_pixel(make_pixel(16'd41,    12'd0,    12'd0,    8'h00, 8'h00, 8'h00, 1'b0));
    queue_pixel(make_pixel(16'd40,    12'd0,    12'd0,    8'hFF, 8'h00, 8'hFF, 1'b0));
    queue_pixel(make_pixel(16'd40960, 12'd4095, 12'd4095, 8'hFF, 8'hFF, 8'hFF, 1'b1));
    queue_pixel(make_pixel(16'd40961, 12'd3,    12'd6,    8'h12, 8'h34, 8'h56, 1'b0));
    queue_pixel(make_pixel(16'd0,     12'd240,  12'd320,  8'h00, 8'hFF, 8'h00, 1'b0));
    queue_pixel(make_pixel(16'hFFFF,  12'd240,  12'd320,  8'hA5, 8'h5A, 8'hC3, 1'b1));
    queue_pixel(make_pixel(16'd4096,  12'd240,  12'd320,  8'h01, 8'h02, 8'h03, 1'b0));
    queue_pixel(make_pixel(16'd4096,  12'd1,    12'd0,    8'h04, 8'h05, 8'h06, 1'b0));
    queue_pixel(make_pixel(16'd4096,  12'd0,    12'd2,    8'h07, 8'h08, 8'h09, 1'b1));
    queue_pixel(make_pixel(16'd8192,  12'd0,    12'd4095, 8'h80, 8'h40, 8'h20, 1'b0));
    wait_idle();

    // Random registers everywhere, plus writes to unused indexes
    write_setting(16'($urandom_range(20000, 65535)) << 16 | $urandom_range(0, 3000),
                  {$urandom, $urandom}, {$urandom, $urandom},
                  {$urandom, $urandom}, {$urandom, $urandom});
    for (int k = dpw_pkg::REG_ROW_Z + 1; k < (1 << CIW); k++)
      write_reg(CIW'(k), {$urandom, $urandom});
    @(posedge clk);
    cfg_we <= 1'b0;
    add_random(150);
    wait_idle();

    // Widest limits, largest intrinsics, full-scale rotation: saturation
    write_setting(32'hFFFF_0000, 64'hFFFF_FFFF_FFFF_FFFF, 64'h7FFF_7FFF_7FFF_7FFF,
                  64'h8000_8000_8000_8000, 64'h8000_0000_0000_0000);
    queue_pixel(make_pixel(16'hFFFF, 12'd4095, 12'd0,    8'h11, 8'h22, 8'h33, 1'b0));
    queue_pixel(make_pixel(16'hFFFF, 12'd0,    12'd4095, 8'h44, 8'h55, 8'h66, 1'b0));
    queue_pixel(make_pixel(16'h0000, 12'd0,    12'd0,    8'h77, 8'h88, 8'h99, 1'b1));
    queue_pixel(make_pixel(16'hFFFF, 12'd4095, 12'd4095, 8'hAA, 8'hBB, 8'hCC, 1'b0));
    add_random(140);
    wait_idle();

    // Minimum above maximum: nothing kept; zero intrinsics and transform
    send_idle_pct = 59;
    write_setting(32'h0000_FFFF, 64'h0, 64'h0, 64'h0, 64'h0);
    add_random(40);
    wait_idle();

    // Plausible camera: identity rotation, random center, focal and offsets
    write_setting(16'($urandom_range(30000, 65535)) << 16 | $urandom_range(0, 500),
                  {16'($urandom_range(40, 400)), 16'($urandom_range(40, 400)),
                   16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535))},
                  {16'($urandom), 32'h0, 16'h4000}, {16'($urandom), 16'h0, 16'h4000, 16'h0},
                  {16'($urandom), 16'h4000, 32'h0});
    add_random(150);
    wait_idle();

    // Single allowed depth at the top of the range
    send_idle_pct = 0;
    write_setting(32'hFFFF_FFFF, {$urandom, $urandom}, {$urandom, $urandom},
                  {$urandom, $urandom}, {$urandom, $urandom});
    add_random(150);
    wait_idle();

    // Back to the power-on registers
    write_setting(dpw_pkg::LIMITS_RESET, dpw_pkg::INTR_RESET, dpw_pkg::ROWX_RESET,
                  dpw_pkg::ROWY_RESET, dpw_pkg::ROWZ_RESET);
    add_random(160);
    wait_idle();

    repeat (DRAIN_WAIT) @(posedge clk);
    if (point_q.size() != 0)
      report_fault($sformatf("%0d predicted points never arrived", point_q.size()));
    if (fault_count == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/dpw_pkg.sv
rtl/dpw_front.sv
rtl/dpw_scale.sv
rtl/dpw_xform.sv
rtl/depth_pixel_to_world_point.sv
verif/tb_top.sv
